// ----- rtl/ffha_pkg.sv -----
// ffha_pkg: shared types and codes for the first-fit heap allocator
// used by ffha_cell and first_fit_heap_allocator; no dependencies
package ffha_pkg;

   typedef struct packed {
      logic        func;
      logic [31:0] alloc_size;
      logic [31:0] free_addr;
   } req_type;

   typedef struct packed {
      logic [31:0] addr;
      logic [1:0]  status;
   } rsp_type;

   typedef struct packed {
      logic [31:0] offset;
      logic [31:0] length;
      logic        used;
   } entry_type;

   // row-wide command from the sequencer to every cell
   typedef enum logic [1:0] {
      CMD_HOLD,
      CMD_INS,
      CMD_DEL
   } cmd_type;

   typedef struct packed {
      cmd_type   cmd;
      entry_type wdata;
      logic      wen;
   } ctl_type;

   localparam logic       FUNC_ALLOC  = 1'b0;
   localparam logic       FUNC_FREE   = 1'b1;
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NOFIT    = 2'd1;
   localparam logic [1:0] ST_BADFREE  = 2'd2;
   localparam logic [0:0] CSR_BASE    = 1'b0;
   localparam logic [0:0] CSR_BYTES   = 1'b1;

endpackage

// ----- rtl/ffha_cell.sv -----
// ffha_cell: one table entry of the chunk row, shifts toward its neighbours
// depends on ffha_pkg
module ffha_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                clear,
   input  ffha_pkg::ctl_type   ctl,
   input  logic                sel,
   input  logic                after,
   input  ffha_pkg::entry_type left,
   input  ffha_pkg::entry_type right,
   output ffha_pkg::entry_type q
);
   import ffha_pkg::*;

   entry_type q_ff, q_in;

   always_comb begin
      q_in = q_ff;
      if (ctl.wen && sel) begin
         q_in = ctl.wdata;
      end else begin
         case (ctl.cmd)
            CMD_INS: if (after) q_in = left;
            CMD_DEL: if (after) q_in = right;
            default: q_in = q_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         q_ff <= '{offset: q_in.offset, length: q_in.length, used: 1'b0};
      end else begin
         q_ff <= q_in;
      end
   end

   assign q = q_ff;
endmodule

// ----- rtl/first_fit_heap_allocator.sv -----
// first_fit_heap_allocator: top level, sequencer and chunk row
// depends on ffha_pkg and ffha_cell
//
// Request beats (req_*) carry func, alloc_size and free_addr; each yields
// exactly one response beat (rsp_*) with addr and status.
// The table is a row of MAX_CHUNKS cells that all compare against the
// request at once; a priority pick selects the first match, then the row
// shifts by one cell for a split (insert) or a merge (delete).
// Allocate: search, pick, write/shift, then the output register.
// Free: search, pick, mark, merge left, merge right; a free with no match skips the merges.
// One request is in flight at a time; a new request is taken only after the
// response of the last one has been taken.
// The response is held in an output register until taken, and req_stall
// is high while busy, while that register is full or during a csr_ write.
// Reset (synchronous, active high) clears both heap registers, all used
// bits and the chunk count, and drops any pending beat.
// A csr_ write reinitialises the table; write only when idle.
// While rsp_stall is high the response holds and no new request is taken.
module first_fit_heap_allocator #(
   parameter int MAX_CHUNKS   = 64,
   parameter int HEADER_BYTES = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ffha_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ffha_pkg::rsp_type rsp_data,
   input  logic              csr_wen,
   input  logic [0:0]        csr_index,
   input  logic [31:0]       csr_wdata
);
   import ffha_pkg::*;

   localparam int IW = $clog2(MAX_CHUNKS);
   localparam int CW = $clog2(MAX_CHUNKS + 1);
   localparam logic [32:0] HB = 33'(HEADER_BYTES);

   typedef enum logic [2:0] {
      S_IDLE, S_SRCH, S_PICK, S_ACT, S_MLEFT, S_MRIGHT, S_OUT
   } state_type;

   state_type      state_ff;
   logic [31:0]    base_ff, bytes_ff;
   logic [CW-1:0]  count_ff;
   req_type        req_ff;
   rsp_type        rsp_ff;
   logic [MAX_CHUNKS-1:0] hit_ff;
   logic [IW-1:0]  idx_ff;
   logic           found_ff;
   logic           clear;
   ctl_type        ctl;
   logic [IW-1:0]  sel_idx;
   logic [IW-1:0]  shift_at;
   logic [31:0]    init_len;
   logic           fix_split_ff;
   entry_type      split_ff;

   entry_type q    [MAX_CHUNKS];
   entry_type cur, prv, nxt;
   logic [MAX_CHUNKS-1:0] hit;
   logic [IW-1:0]  pick;
   logic           pick_ok;

   assign clear = csr_wen;
   assign init_len = (csr_index == CSR_BYTES ? csr_wdata : bytes_ff) - HB[31:0];

   genvar g;
   generate
      for (g = 0; g < MAX_CHUNKS; g++) begin : g_row
         entry_type lft, rgt;
         if (g == 0) begin : g_l0
            assign lft = q[0];
         end else begin : g_l
            assign lft = q[g-1];
         end
         if (g == MAX_CHUNKS - 1) begin : g_rl
            assign rgt = q[g];
         end else begin : g_r
            assign rgt = q[g+1];
         end
         ffha_cell u_cell (
            .clock (clock),
            .reset (reset),
            .clear (clear),
            .ctl   (ctl),
            .sel   (sel_idx == IW'(g)),
            .after (IW'(g) > shift_at),
            .left  (lft),
            .right (rgt),
            .q     (q[g])
         );
         always_comb begin
            if (CW'(g) >= count_ff) begin
               hit[g] = 1'b0;
            end else if (req_ff.func == FUNC_ALLOC) begin
               hit[g] = !q[g].used && q[g].length != 32'd0
                        && q[g].length >= req_ff.alloc_size;
            end else begin
               hit[g] = (base_ff + q[g].offset + HB[31:0]) == req_ff.free_addr;
            end
         end
      end
   endgenerate

   always_comb begin
      pick = '0;
      pick_ok = 1'b0;
      for (int i = MAX_CHUNKS - 1; i >= 0; i--) begin
         if (hit_ff[i]) begin
            pick = IW'(i);
            pick_ok = 1'b1;
         end
      end
   end

   assign cur = q[idx_ff];
   assign prv = q[idx_ff - IW'(1)];
   assign nxt = q[idx_ff + IW'(1)];

   logic [32:0] need;
   logic        do_split;
   logic [32:0] msum;
   assign need     = {1'b0, req_ff.alloc_size} + HB + 33'd1;
   assign do_split = ({1'b0, cur.length} >= need) && (count_ff < CW'(MAX_CHUNKS));

   always_comb begin
      ctl      = '{cmd: CMD_HOLD, wdata: cur, wen: 1'b0};
      sel_idx  = idx_ff;
      shift_at = idx_ff;
      msum     = '0;
      unique case (state_ff)
         S_ACT: begin
            if (found_ff && req_ff.func == FUNC_ALLOC) begin
               ctl.wen = 1'b1;
               ctl.wdata.used = 1'b1;
               if (do_split) begin
                  ctl.cmd = CMD_INS;
                  ctl.wdata.length = req_ff.alloc_size;
               end
            end else if (found_ff) begin
               ctl.wen = 1'b1;
               ctl.wdata.used = 1'b0;
            end
         end
         S_MLEFT: begin
            if (idx_ff != '0 && !prv.used) begin
               msum = {1'b0, prv.length} + {1'b0, cur.length} + HB;
               ctl.cmd = CMD_DEL;
               ctl.wen = 1'b1;
               sel_idx = idx_ff - IW'(1);
               shift_at = idx_ff - IW'(1);
               ctl.wdata = prv;
               ctl.wdata.length = msum[31:0];
            end
         end
         S_MRIGHT: begin
            if (CW'(idx_ff) + CW'(1) < count_ff && !nxt.used) begin
               msum = {1'b0, cur.length} + {1'b0, nxt.length} + HB;
               ctl.cmd = CMD_DEL;
               ctl.wen = 1'b1;
               ctl.wdata.length = msum[31:0];
            end
         end
         default: ;
      endcase
      // free remainder lands in the cell right after the split chunk
      if (fix_split_ff) begin
         ctl.wen   = 1'b1;
         ctl.wdata = split_ff;
         sel_idx   = idx_ff + IW'(1);
      end
      // a register write leaves one free chunk at offset zero, or none if the heap is smaller than a header
      if (csr_wen) begin
         ctl = '{cmd: CMD_HOLD,
                 wdata: '{offset: 32'd0, length: init_len, used: 1'b0},
                 wen: 1'b1};
         sel_idx = '0;
      end
   end

   logic [32:0] soff, slen;
   assign soff = {1'b0, cur.offset} + HB + {1'b0, req_ff.alloc_size};
   assign slen = {1'b0, cur.length} - {1'b0, req_ff.alloc_size} - HB;

   always_ff @(posedge clock) begin
      hit_ff   <= hit;
      split_ff <= '{offset: soff[31:0], length: slen[31:0], used: 1'b0};
      if (reset) begin
         state_ff     <= S_IDLE;
         base_ff      <= '0;
         bytes_ff     <= '0;
         count_ff     <= '0;
         fix_split_ff <= 1'b0;
         found_ff     <= 1'b0;
      end else if (csr_wen) begin
         if (csr_index == CSR_BASE) begin
            base_ff <= csr_wdata;
         end else begin
            bytes_ff <= csr_wdata;
         end
         count_ff <= ((csr_index == CSR_BYTES ? csr_wdata : bytes_ff) >= HB[31:0])
                     ? CW'(1) : CW'(0);
         fix_split_ff <= 1'b0;
      end else begin
         fix_split_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  req_ff   <= req_data;
                  state_ff <= S_SRCH;
               end
            end
            S_SRCH: state_ff <= S_PICK;
            S_PICK: begin
               idx_ff   <= pick;
               found_ff <= pick_ok;
               state_ff <= S_ACT;
            end
            S_ACT: begin
               if (!found_ff) begin
                  rsp_ff <= '{addr: 32'd0,
                     status: (req_ff.func == FUNC_ALLOC) ? ST_NOFIT : ST_BADFREE};
                  state_ff <= S_OUT;
               end else if (req_ff.func == FUNC_ALLOC) begin
                  rsp_ff <= '{addr: base_ff + cur.offset + HB[31:0], status: ST_OK};
                  if (do_split) begin
                     count_ff     <= count_ff + CW'(1);
                     fix_split_ff <= 1'b1;
                  end
                  state_ff <= S_OUT;
               end else begin
                  rsp_ff   <= '{addr: 32'd0, status: ST_OK};
                  state_ff <= S_MLEFT;
               end
            end
            S_MLEFT: begin
               if (ctl.cmd == CMD_DEL) begin
                  count_ff <= count_ff - CW'(1);
                  idx_ff   <= idx_ff - IW'(1);
               end
               state_ff <= S_MRIGHT;
            end
            S_MRIGHT: begin
               if (ctl.cmd == CMD_DEL) begin
                  count_ff <= count_ff - CW'(1);
               end
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (!rsp_stall) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_stall = (state_ff != S_IDLE) || csr_wen;
   assign rsp_valid = (state_ff == S_OUT);
   assign rsp_data  = rsp_ff;
endmodule
